// ----- rtl/assert_macros.svh -----
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define KPRFC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Expression must never be true at a clock edge outside reset.
`define KPRFC_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// ----- rtl/kprfc_pkg.sv -----
`default_nettype none

package kprfc_pkg;

  // Default receive buffer size (bytes)
  localparam int unsigned DefaultBufBytes = 32;

  // Item function codes
  localparam logic [1:0] FUNC_START   = 2'd0;
  localparam logic [1:0] FUNC_BYTE    = 2'd1;
  localparam logic [1:0] FUNC_TIMEOUT = 2'd2;

  // Result status codes
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_NO_RESP  = 2'd1;
  localparam logic [1:0] STATUS_BAD_ADDR = 2'd2;
  localparam logic [1:0] STATUS_BAD_SUM  = 2'd3;

  // Frame kinds
  localparam logic [1:0] KIND_KEY     = 2'd0;
  localparam logic [1:0] KIND_POWERUP = 2'd1;
  localparam logic [1:0] KIND_OTHER   = 2'd2;

  // Frame type constants
  localparam logic [7:0] TYPE_POWERUP = 8'h87;
  localparam logic [7:0] KEY_MAX_LEN  = 8'd16;
  localparam int unsigned PowerupLen  = 9;
  localparam int unsigned HeaderLen   = 2;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] data_byte;
    logic [5:0] target_addr;
  } item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [1:0] kind;
    logic [7:0] type_byte;
    logic [5:0] frame_len;
    logic [7:0] ack_byte;
  } result_t;

  // Item held in the input register
  typedef struct packed {
    logic  valid;
    item_t item;
  } in_beat_t;

  // Result produced by the frame engine for one step
  typedef struct packed {
    logic    valid;
    result_t res;
  } res_beat_t;

  // Frame kind from the second header byte
  function automatic logic [1:0] frame_kind(input logic [7:0] type_byte);
    logic [1:0] k;
    if (type_byte == TYPE_POWERUP) begin
      k = KIND_POWERUP;
    end else if (type_byte <= KEY_MAX_LEN) begin
      k = KIND_KEY;
    end else begin
      k = KIND_OTHER;
    end
    return k;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/kprfc_item_if.sv -----
`default_nettype none

// Received-item channel
interface kprfc_item_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [7:0] data_byte;
  logic [5:0] target_addr;

  modport source (output valid, output func, output data_byte, output target_addr,
                  input ready);
  modport sink   (input valid, input func, input data_byte, input target_addr,
                  output ready);
endinterface

`default_nettype wire

// ----- rtl/kprfc_result_if.sv -----
`default_nettype none

// Frame result channel
interface kprfc_result_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [1:0] kind;
  logic [7:0] type_byte;
  logic [5:0] frame_len;
  logic [7:0] ack_byte;

  modport source (output valid, output status, output kind, output type_byte,
                  output frame_len, output ack_byte, input ready);
  modport sink   (input valid, input status, input kind, input type_byte,
                  input frame_len, input ack_byte, output ready);
endinterface

`default_nettype wire

// ----- rtl/kprfc_in_reg.sv -----
`default_nettype none

// Input register: captures one item beat, released when the engine steps
module kprfc_in_reg (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                valid_i,
  input  wire kprfc_pkg::item_t    item_i,
  output logic                     ready_o,
  input  wire logic                advance_i,
  output kprfc_pkg::in_beat_t      beat_o
);
  import kprfc_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q;

  assign ready_o = !valid_q || advance_i;

  always_comb begin
    valid_d = valid_q;
    if (ready_o) begin
      valid_d = valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_i;
    end
  end

  assign beat_o.valid = valid_q;
  assign beat_o.item  = item_q;
endmodule

`default_nettype wire

// ----- rtl/kprfc_frame_engine.sv -----
`default_nettype none

// Frame state and per-byte update; result is combinational from state and item
module kprfc_frame_engine #(
  parameter int unsigned BUF_BYTES = kprfc_pkg::DefaultBufBytes
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                step_i,
  input  wire kprfc_pkg::item_t    item_i,
  output kprfc_pkg::res_beat_t     res_o
);
  import kprfc_pkg::*;

  localparam int unsigned CntW = $clog2(BUF_BYTES + 1);

  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_FIRST  = 2'd1;
  localparam logic [1:0] PH_SECOND = 2'd2;
  localparam logic [1:0] PH_BODY   = 2'd3;

  logic [1:0]      phase_q, phase_d;
  logic [5:0]      exp_addr_q, exp_addr_d;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] total_q, total_d;
  logic [7:0]      sum_q, sum_d;
  logic [7:0]      first_q, first_d;
  logic [7:0]      second_q, second_d;
  logic [7:0]      last_q, last_d;

  logic            fin, hdr_tmo, is_tmo;
  logic [7:0]      fin_sum, fin_last, fin_second, body_v, open_sum;
  logic [CntW-1:0] fin_count, count_inc;
  logic [1:0]      status;

  assign is_tmo    = (item_i.func == FUNC_TIMEOUT);
  assign count_inc = count_q + CntW'(1);
  assign body_v    = is_tmo ? 8'h00 : item_i.data_byte;
  // Open frames fold the previous byte in once a body byte has been seen
  assign open_sum  = (count_q >= CntW'(3)) ? 8'(sum_q + last_q) : sum_q;

  // Next state and frame end detection
  always_comb begin
    phase_d    = phase_q;
    exp_addr_d = exp_addr_q;
    count_d    = count_q;
    total_d    = total_q;
    sum_d      = sum_q;
    first_d    = first_q;
    second_d   = second_q;
    last_d     = last_q;
    fin        = 1'b0;
    hdr_tmo    = 1'b0;
    fin_sum    = sum_q;
    fin_last   = last_q;
    fin_second = second_q;
    fin_count  = count_q;

    if (step_i) begin
      case (item_i.func) inside
        FUNC_START: begin
          exp_addr_d = item_i.target_addr;
          phase_d    = PH_FIRST;
          count_d    = '0;
          total_d    = '0;
          sum_d      = '0;
          first_d    = '0;
          second_d   = '0;
          last_d     = '0;
        end
        FUNC_BYTE, FUNC_TIMEOUT: begin
          unique case (phase_q)
            PH_IDLE: begin
            end
            PH_FIRST: begin
              if (is_tmo) begin
                hdr_tmo = 1'b1;
                phase_d = PH_IDLE;
              end else begin
                first_d = item_i.data_byte;
                sum_d   = item_i.data_byte;
                count_d = CntW'(1);
                phase_d = PH_SECOND;
              end
            end
            PH_SECOND: begin
              if (is_tmo) begin
                hdr_tmo = 1'b1;
                phase_d = PH_IDLE;
              end else begin
                second_d = item_i.data_byte;
                sum_d    = 8'(sum_q + item_i.data_byte);
                last_d   = item_i.data_byte;
                count_d  = CntW'(HeaderLen);
                phase_d  = PH_BODY;
                if (item_i.data_byte == TYPE_POWERUP) begin
                  total_d = CntW'(PowerupLen);
                end else if (item_i.data_byte <= KEY_MAX_LEN) begin
                  total_d = CntW'(item_i.data_byte) + CntW'(HeaderLen);
                end else begin
                  total_d = CntW'(BUF_BYTES);
                end
                // Zero-length key frame ends on its type byte
                if (item_i.data_byte == 8'h00) begin
                  fin        = 1'b1;
                  fin_sum    = 8'(sum_q + item_i.data_byte);
                  fin_last   = item_i.data_byte;
                  fin_second = item_i.data_byte;
                  fin_count  = CntW'(HeaderLen);
                end
              end
            end
            PH_BODY: begin
              if (frame_kind(second_q) != KIND_OTHER) begin
                // Fixed frame: timeout stands for a zero byte
                count_d = count_inc;
                if (count_inc >= total_q) begin
                  last_d    = body_v;
                  fin       = 1'b1;
                  fin_last  = body_v;
                  fin_count = count_inc;
                end else begin
                  sum_d = 8'(sum_q + body_v);
                end
              end else if (is_tmo) begin
                fin = 1'b1;
              end else begin
                sum_d   = open_sum;
                last_d  = item_i.data_byte;
                count_d = count_inc;
                if (count_inc >= total_q) begin
                  fin       = 1'b1;
                  fin_sum   = open_sum;
                  fin_last  = item_i.data_byte;
                  fin_count = count_inc;
                end
              end
            end
            default: begin
            end
          endcase
        end
        default: begin
        end
      endcase
      if (fin) begin
        phase_d = PH_IDLE;
      end
    end
  end

  // Address and checksum checks
  always_comb begin
    if (first_q[5:0] != exp_addr_q) begin
      status = STATUS_BAD_ADDR;
    end else if (8'(8'h00 - fin_sum) != fin_last) begin
      status = STATUS_BAD_SUM;
    end else begin
      status = STATUS_OK;
    end
  end

  always_comb begin
    res_o.valid = fin || hdr_tmo;
    if (hdr_tmo) begin
      res_o.res = '{status: STATUS_NO_RESP, kind: KIND_KEY, type_byte: 8'h00,
                    frame_len: 6'd0, ack_byte: 8'h00};
    end else begin
      res_o.res = '{status: status, kind: frame_kind(fin_second), type_byte: fin_second,
                    frame_len: 6'(fin_count), ack_byte: first_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      exp_addr_q <= '0;
      count_q    <= '0;
      total_q    <= '0;
      sum_q      <= '0;
      first_q    <= '0;
      second_q   <= '0;
      last_q     <= '0;
    end else begin
      phase_q    <= phase_d;
      exp_addr_q <= exp_addr_d;
      count_q    <= count_d;
      total_q    <= total_d;
      sum_q      <= sum_d;
      first_q    <= first_d;
      second_q   <= second_d;
      last_q     <= last_d;
    end
  end
endmodule

`default_nettype wire

// ----- rtl/kprfc_out_reg.sv -----
`default_nettype none

// Result register: holds one result until the sink takes it
module kprfc_out_reg (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  step_i,
  input  wire kprfc_pkg::res_beat_t  res_i,
  output logic                       advance_o,
  output logic                       valid_o,
  input  wire logic                  ready_i,
  output kprfc_pkg::result_t         res_o
);
  import kprfc_pkg::*;

  logic    valid_q, valid_d;
  logic    load;
  result_t res_q;

  // Engine may step when the register is empty or being emptied
  assign advance_o = !valid_q || ready_i;
  assign load      = step_i && res_i.valid;

  always_comb begin
    valid_d = valid_q;
    if (advance_o) begin
      valid_d = load;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o && load) begin
      res_q <= res_i.res;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;
endmodule

`default_nettype wire

// ----- rtl/keypad_reply_frame_checker.sv -----
// Keypad reply frame checker. Send a start beat carrying the polled address, then one beat per
// received byte or byte timeout; at the end of each frame (or on a timeout in the two header
// bytes) one result beat reports status, kind, type byte, length and the acknowledgement byte.
// An accepted item waits in the input register and is folded into the frame state when the
// engine steps, which also loads any result it causes into the output register; a result is
// offered from the output register once the beat that ends its frame has passed through the
// input register, and a beat can be taken every cycle. A result stays in the output register
// until taken, while one more item may wait in the input register. The input only stalls when
// both registers hold beats and the result is not being taken.
`default_nettype none

`include "assert_macros.svh"

module keypad_reply_frame_checker #(
  parameter int unsigned BUF_BYTES = kprfc_pkg::DefaultBufBytes
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  kprfc_item_if.sink      item_i,
  kprfc_result_if.source  result_o
);
  import kprfc_pkg::*;

  in_beat_t  in_beat;
  res_beat_t res_beat;
  result_t   res_data;
  item_t     item_in;
  logic      advance;
  logic      step;

  assign item_in = '{func: item_i.func, data_byte: item_i.data_byte,
                     target_addr: item_i.target_addr};
  assign step    = in_beat.valid && advance;

  kprfc_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (item_i.valid),
    .item_i    (item_in),
    .ready_o   (item_i.ready),
    .advance_i (advance),
    .beat_o    (in_beat)
  );

  kprfc_frame_engine #(
    .BUF_BYTES (BUF_BYTES)
  ) u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (in_beat.item),
    .res_o  (res_beat)
  );

  kprfc_out_reg u_out_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .res_i     (res_beat),
    .advance_o (advance),
    .valid_o   (result_o.valid),
    .ready_i   (result_o.ready),
    .res_o     (res_data)
  );

  assign result_o.status    = res_data.status;
  assign result_o.kind      = res_data.kind;
  assign result_o.type_byte = res_data.type_byte;
  assign result_o.frame_len = res_data.frame_len;
  assign result_o.ack_byte  = res_data.ack_byte;

  // Checks
  `KPRFC_ASSERT(a_accept_fills_in_reg, clk_i, rst_ni,
    item_i.valid && item_i.ready |=> in_beat.valid,
    "accepted beat not held in input register")
  `KPRFC_ASSERT_NEVER(a_stall_blocks_input, clk_i, rst_ni,
    result_o.valid && !result_o.ready && in_beat.valid && item_i.ready,
    "input ready while both stages are blocked")
  `KPRFC_ASSERT(a_no_resp_fields_zero, clk_i, rst_ni,
    result_o.valid && result_o.status == STATUS_NO_RESP |-> result_o.frame_len == 6'd0 &&
    result_o.ack_byte == 8'h00 && result_o.type_byte == 8'h00,
    "no-response result carries frame fields")
endmodule

`default_nettype wire

// ----- sim/testbench.sv -----
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import kprfc_pkg::*;

  localparam int unsigned BufBytes   = DefaultBufBytes;
  localparam int unsigned RandItems  = 1000;
  localparam int unsigned QuietItems = 200;
  localparam int unsigned TailCycles = 8;
  localparam int unsigned IdleLimit  = 400;

  // func code that the block must ignore
  localparam logic [1:0] FUNC_SPARE = 2'd3;

  typedef enum logic [1:0] {RX_IDLE, RX_FIRST, RX_SECOND, RX_BODY} rx_phase_e;

  logic clk;
  logic rst_n;

  kprfc_item_if   item_ch ();
  kprfc_result_if reply_ch ();

  keypad_reply_frame_checker #(
    .BUF_BYTES(BufBytes)
  ) dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .item_i  (item_ch),
    .result_o(reply_ch)
  );

  // Frame tracker state
  rx_phase_e   rx_phase;
  logic [5:0]  rx_addr;
  int unsigned rx_count;
  int unsigned rx_total;
  logic [7:0]  rx_sum;
  logic [7:0]  rx_first;
  logic [7:0]  rx_second;
  logic [7:0]  rx_last;

  result_t     pending_replies[$];
  int unsigned mismatches;
  int unsigned items_taken;
  int unsigned replies_taken;
  int unsigned status_seen[4];
  int unsigned idle_cycles;
  int unsigned gap_pct;
  int unsigned sink_hold;
  bit          quiet;

  // Clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 50) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // End of frame: address then checksum, address failure wins
  function automatic result_t close_frame();
    result_t    r;
    logic [7:0] want_sum;
    want_sum = 8'h00 - rx_sum;
    if (rx_first[5:0] != rx_addr) r.status = STATUS_BAD_ADDR;
    else if (want_sum != rx_last) r.status = STATUS_BAD_SUM;
    else r.status = STATUS_OK;
    if (rx_second == TYPE_POWERUP) r.kind = KIND_POWERUP;
    else if (rx_second > KEY_MAX_LEN) r.kind = KIND_OTHER;
    else r.kind = KIND_KEY;
    r.type_byte = rx_second;
    r.frame_len = rx_count[5:0];
    r.ack_byte  = rx_first;
    rx_phase    = RX_IDLE;
    return r;
  endfunction

  // Fold one accepted beat into the tracker; returns 1 when a reply is due
  function automatic bit advance_frame(input item_t it, output result_t rep);
    logic [7:0] v;
    bit         is_tmo;
    rep    = '0;
    is_tmo = (it.func == FUNC_TIMEOUT);
    if (it.func == FUNC_START) begin
      rx_phase  = RX_FIRST;
      rx_addr   = it.target_addr;
      rx_count  = 0;
      rx_total  = 0;
      rx_sum    = '0;
      rx_first  = '0;
      rx_second = '0;
      rx_last   = '0;
      return 1'b0;
    end
    if (!(it.func == FUNC_BYTE || is_tmo) || rx_phase == RX_IDLE) return 1'b0;

    // header bytes
    if (rx_phase != RX_BODY) begin
      if (is_tmo) begin
        rep.status = STATUS_NO_RESP;
        rx_phase   = RX_IDLE;
        return 1'b1;
      end
      if (rx_phase == RX_FIRST) begin
        rx_first = it.data_byte;
        rx_sum   = it.data_byte;
        rx_count = 1;
        rx_phase = RX_SECOND;
        return 1'b0;
      end
      rx_second = it.data_byte;
      rx_sum    = rx_sum + it.data_byte;
      rx_last   = it.data_byte;
      rx_count  = 2;
      if (it.data_byte == TYPE_POWERUP) rx_total = PowerupLen;
      else if (it.data_byte <= KEY_MAX_LEN) rx_total = it.data_byte + HeaderLen;
      else rx_total = BufBytes;
      rx_phase = RX_BODY;
      if (rx_total <= HeaderLen) begin
        rep = close_frame();
        return 1'b1;
      end
      return 1'b0;
    end

    // fixed-length body: a timeout stands for a zero byte
    if (rx_second == TYPE_POWERUP || rx_second <= KEY_MAX_LEN) begin
      v = is_tmo ? 8'h00 : it.data_byte;
      rx_count++;
      if (rx_count >= rx_total) begin
        rx_last = v;
        rep     = close_frame();
        return 1'b1;
      end
      rx_sum = rx_sum + v;
      return 1'b0;
    end

    // open-length body: the latest byte is held back as the checksum
    if (is_tmo) begin
      rep = close_frame();
      return 1'b1;
    end
    if (rx_count >= 3) rx_sum = rx_sum + rx_last;
    rx_last = it.data_byte;
    rx_count++;
    if (rx_count >= rx_total) begin
      rep = close_frame();
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Monitor: check reply beats, then predict from item beats
  always @(posedge clk) begin
    item_t   it;
    result_t got;
    result_t want;
    if (rst_n) begin
      if (reply_ch.valid && reply_ch.ready) begin
        got.status    = reply_ch.status;
        got.kind      = reply_ch.kind;
        got.type_byte = reply_ch.type_byte;
        got.frame_len = reply_ch.frame_len;
        got.ack_byte  = reply_ch.ack_byte;
        replies_taken++;
        status_seen[got.status]++;
        if (pending_replies.size() == 0) begin
          report_mismatch("reply beat with no reply pending");
        end else begin
          want = pending_replies.pop_front();
          if (got.status !== want.status)
            report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
          if (got.kind !== want.kind)
            report_mismatch($sformatf("kind %0d, want %0d", got.kind, want.kind));
          if (got.type_byte !== want.type_byte)
            report_mismatch($sformatf("type_byte %h, want %h", got.type_byte,
                                      want.type_byte));
          if (got.frame_len !== want.frame_len)
            report_mismatch($sformatf("frame_len %0d, want %0d", got.frame_len,
                                      want.frame_len));
          if (got.ack_byte !== want.ack_byte)
            report_mismatch($sformatf("ack_byte %h, want %h", got.ack_byte, want.ack_byte));
        end
      end
      if (item_ch.valid && item_ch.ready) begin
        it.func        = item_ch.func;
        it.data_byte   = item_ch.data_byte;
        it.target_addr = item_ch.target_addr;
        items_taken++;
        if (advance_frame(it, want)) pending_replies.push_back(want);
      end
    end
  end

  // Reply sink with random stall bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      sink_hold      <= 0;
      reply_ch.ready <= 1'b0;
    end else if (sink_hold != 0) begin
      sink_hold      <= sink_hold - 1;
      reply_ch.ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 99) < gap_pct) begin
      sink_hold      <= $urandom_range(0, 5);
      reply_ch.ready <= 1'b0;
    end else begin
      reply_ch.ready <= 1'b1;
    end
  end

  // Watchdog on cycles with no beat on either channel
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else begin
      if ((item_ch.valid && item_ch.ready) || (reply_ch.valid && reply_ch.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IdleLimit) begin
        $display("watchdog: no beat for %0d cycles", IdleLimit);
        $display("FAILED: results differ");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // One item beat, with an optional idle burst ahead of it
  task automatic send_item(input logic [1:0] f, input logic [7:0] d, input logic [5:0] a);
    if (!quiet && $urandom_range(0, 99) < gap_pct) begin
      item_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    item_ch.valid       <= 1'b1;
    item_ch.func        <= f;
    item_ch.data_byte   <= d;
    item_ch.target_addr <= a;
    do @(posedge clk); while (!item_ch.ready);
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_item(FUNC_BYTE, b, 6'($urandom));
  endtask

  task automatic send_timeout();
    send_item(FUNC_TIMEOUT, 8'($urandom), 6'($urandom));
  endtask

  // Hold the sender off until every pending reply has come back
  task automatic wait_drained();
    item_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_replies.size() != 0);
  endtask

  // Stray beats while idle, including the unused func code
  task automatic test_idle_noise();
    send_item(FUNC_BYTE, 8'hFF, 6'h3F);
    send_item(FUNC_TIMEOUT, 8'h00, 6'h00);
    send_item(FUNC_SPARE, 8'hAA, 6'h15);
  endtask

  // Timeout on the first and on the second header byte
  task automatic test_header_timeout();
    send_item(FUNC_START, 8'h00, 6'h3F);
    send_timeout();
    send_item(FUNC_START, 8'hFF, 6'h00);
    send_byte(8'h00);
    send_timeout();
  endtask

  // Zero-length key frame, and an open frame with no body
  task automatic test_short_frames();
    send_item(FUNC_START, 8'h00, 6'h00);
    send_byte(8'h00);
    send_byte(8'h00);
    send_item(FUNC_START, 8'h00, 6'h02);
    send_byte(8'h02);
    send_byte(8'hFF);
    send_timeout();
  endtask

  // Restart mid-frame, spare code mid-frame, timeout as a zero body byte,
  // then a frame failing both address and checksum
  task automatic test_restart_and_errors();
    send_item(FUNC_START, 8'h00, 6'h00);
    send_byte(8'h12);
    send_item(FUNC_START, 8'h00, 6'h3F);
    send_item(FUNC_SPARE, 8'h00, 6'h00);
    send_byte(8'h3F);
    send_byte(8'h02);
    send_timeout();
    send_byte(8'hBF);
    send_item(FUNC_START, 8'h00, 6'h01);
    send_byte(8'h00);
    send_byte(8'h01);
    send_byte(8'h55);
  endtask

  // One random frame: mostly well-formed, some broken, some noise after
  task automatic send_random_frame();
    logic [7:0]  frame_q[$];
    bit          tmo_q[$];
    logic [5:0]  addr;
    logic [7:0]  first;
    logic [7:0]  ftype;
    logic [7:0]  sum;
    logic [1:0]  f;
    int unsigned scen;
    int unsigned total;
    int unsigned pick;
    bit          open_len;
    case ($urandom_range(0, 3))
      0: gap_pct = 0;
      1: gap_pct = 10;
      2: gap_pct = 25;
      default: gap_pct = 50;
    endcase
    addr  = 6'($urandom);
    first = 8'($urandom);
    first[5:0] = addr;
    if ($urandom_range(0, 9) == 0) first[5:0] = addr ^ 6'($urandom_range(1, 63));
    send_item(FUNC_START, 8'($urandom), addr);
    scen = $urandom_range(0, 99);

    if (scen < 8) begin
      // header cut short by a timeout
      if ($urandom_range(0, 1) != 0) send_byte(first);
      send_timeout();
    end else if (scen < 14) begin
      // abandoned: the next start drops it
      repeat ($urandom_range(0, 5)) send_byte(8'($urandom));
    end else begin
      if (scen < 55) ftype = 8'($urandom_range(0, KEY_MAX_LEN));
      else if (scen < 68) ftype = TYPE_POWERUP;
      else begin
        do ftype = 8'($urandom_range(KEY_MAX_LEN + 1, 255)); while (ftype == TYPE_POWERUP);
      end
      open_len = (ftype != TYPE_POWERUP) && (ftype > KEY_MAX_LEN);
      if (ftype == TYPE_POWERUP) total = PowerupLen;
      else if (!open_len) total = ftype + HeaderLen;
      else if ($urandom_range(0, 5) == 0) total = $urandom_range(11, BufBytes);
      else total = $urandom_range(HeaderLen, 10);
      frame_q = {first, ftype};
      tmo_q   = {1'b0, 1'b0};
      // body bytes, some zero and some of those sent as timeouts
      while (frame_q.size() + 1 < total) begin
        if ($urandom_range(0, 7) == 0) begin
          frame_q.push_back(8'h00);
          tmo_q.push_back(!open_len && $urandom_range(0, 1) != 0);
        end else begin
          frame_q.push_back(8'($urandom));
          tmo_q.push_back(1'b0);
        end
      end
      // checksum byte, corrupted now and then
      if (total > HeaderLen) begin
        sum = '0;
        foreach (frame_q[i]) sum = sum + frame_q[i];
        sum = 8'h00 - sum;
        if ($urandom_range(0, 9) == 0) sum = sum ^ 8'($urandom_range(1, 255));
        frame_q.push_back(sum);
        tmo_q.push_back(!open_len && sum == 8'h00 && $urandom_range(0, 1) != 0);
      end
      foreach (frame_q[i]) begin
        if (tmo_q[i]) send_timeout();
        else send_byte(frame_q[i]);
      end
      if (open_len && total < BufBytes) send_timeout();
    end

    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        pick = $urandom_range(0, 2);
        f = (pick == 0) ? FUNC_BYTE : (pick == 1) ? FUNC_TIMEOUT : FUNC_SPARE;
        send_item(f, 8'($urandom), 6'($urandom));
      end
    end
  endtask

  // Random frames with idling on both sides and occasional full drains
  task automatic test_random_frames();
    int unsigned stop_at;
    stop_at = items_taken + RandItems;
    while (items_taken < stop_at) begin
      send_random_frame();
      if ($urandom_range(0, 15) == 0) wait_drained();
    end
  endtask

  // Closing stretch at full rate on both sides
  task automatic test_full_rate_frames();
    int unsigned stop_at;
    quiet   = 1'b1;
    stop_at = items_taken + QuietItems;
    while (items_taken < stop_at) send_random_frame();
  endtask

  initial begin
    rst_n                = 1'b0;
    item_ch.valid        = 1'b0;
    item_ch.func         = FUNC_SPARE;
    item_ch.data_byte    = '0;
    item_ch.target_addr  = '0;
    rx_phase             = RX_IDLE;
    rx_addr              = '0;
    rx_count             = 0;
    rx_total             = 0;
    rx_sum               = '0;
    rx_first             = '0;
    rx_second            = '0;
    rx_last              = '0;
    mismatches           = 0;
    items_taken          = 0;
    replies_taken        = 0;
    status_seen          = '{default: 0};
    gap_pct              = 20;
    quiet                = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_idle_noise();
    test_header_timeout();
    test_short_frames();
    test_restart_and_errors();
    wait_drained();
    test_random_frames();
    test_full_rate_frames();
    wait_drained();
    repeat (TailCycles) @(posedge clk);

    $display("Run covered %0d item beats and %0d reply beats", items_taken, replies_taken);
    $display("Replies: %0d accepted, %0d no response, %0d wrong address, %0d bad checksum",
             status_seen[STATUS_OK], status_seen[STATUS_NO_RESP],
             status_seen[STATUS_BAD_ADDR], status_seen[STATUS_BAD_SUM]);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
